FILE: rtl/core/nep_pkg.sv
// Shared constants and types for the nibble entropy pool.
// No dependencies; imported by the pool top level.
`default_nettype none

package nep_pkg;

	// Pool geometry
	localparam int POOL_WORDS      = 16;
	localparam int CHUNKS_PER_WORD = 8;
	localparam int NCHUNKS         = POOL_WORDS * CHUNKS_PER_WORD;
	localparam int PTR_W           = $clog2(NCHUNKS);
	localparam int WIDX_W          = $clog2(POOL_WORDS);
	localparam int SEL_W           = $clog2(CHUNKS_PER_WORD);

	// Field widths
	localparam int NIB_W    = 4;
	localparam int WORD_W   = 32;
	localparam int FILL_W   = 7;
	localparam int CNT_W    = $clog2(WORD_W);
	localparam int STAT_W   = 2;

	localparam logic [NIB_W-1:0] NIB_MASK = 4'hF;

	// Request kinds
	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_GET    = 1'b1
	} opcode_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/core/nep_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
`default_nettype none

module nep_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/nibble_entropy_pool.sv
// Top level of the nibble entropy pool: ring buffer control, nibble merge and
// a bit-serial remainder unit. Depends on nep_pkg and nep_ram.
`default_nettype none

// Ring-buffer pool of 4-bit entropy chunks packed eight to a 32-bit word and
// held in one RAM of POOL_WORDS words (no clearing pass; unwritten words are
// never read as valid data). A request with tuser 0 appends the low nibble of
// tdata; the pool holds at most POOL_WORDS*8-1 nibbles and a full pool drops
// the nibble and reports status 1 with source_enable low. A request with
// tuser 1 takes the word at the read pointer once 8 or more nibbles are held
// (else status 2) and reduces it modulo the request's bound unless the bound
// is zero. A rejected request (full pool on append, fewer than 8 nibbles on
// get) goes from acceptance straight to S_DONE; an append passes through
// S_MERGE and a get through S_LOAD, and a get with a nonzero bound then runs
// S_DIV, the remainder unit retiring one quotient bit per cycle after the
// word is loaded. The RAM read-modify-write of an append reads the word at
// acceptance and writes the merged word in S_MERGE. s_tready returns in the
// same cycle that the result enters the output register. One request is in
// flight at a time; a finished result waits in the output register while
// the next request is accepted, and a result that cannot enter the output
// register holds the sequencer until m_tready frees it.
module nibble_entropy_pool
	import nep_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // nibble[3:0], bound[35:4], zero[39:36]
	input  wire logic [0:0]  s_tuser,  // opcode[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // random_value[31:0], fill_level[38:32],
	                                   // source_enable[39]
	output logic      [1:0]  m_tuser   // status[1:0]
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MERGE = 5'b00010,
		S_LOAD  = 5'b00100,
		S_DIV   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [PTR_W-1:0]  wp_q, rp_q, held_q;
	logic              out_valid_q;

	// Request-side payload and working registers
	logic [NIB_W-1:0]  nib_q;
	logic [SEL_W-1:0]  wsel_q;
	logic [WIDX_W-1:0] waddr_q;
	logic [WORD_W-1:0] bound_q;
	logic [WORD_W-1:0] dvd_q, rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] res_value_q;
	status_t           res_status_q;

	// Output register payload
	logic [WORD_W-1:0] out_value_q;
	status_t           out_status_q;
	logic [FILL_W-1:0] out_fill_q;
	logic              out_en_q;

	// Request fields
	logic [NIB_W-1:0]  in_nib;
	logic [WORD_W-1:0] in_bound;
	opcode_t           in_op;
	logic              s_acc;
	logic              out_free;

	// Pointer arithmetic
	logic [PTR_W-1:0]  wp_inc, rp_inc;
	logic              pool_full, pool_short;

	// RAM ports
	logic              ram_re, ram_we;
	logic [WIDX_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;
	logic [CNT_W-1:0]  nib_shamt;

	// Remainder step
	logic [WORD_W:0]   rem_shift;
	logic [WORD_W:0]   rem_sub;
	logic [WORD_W-1:0] rem_next;

	// Fill level, masked to its field width at any pool size
	logic [PTR_W+FILL_W-1:0] held_ext;

	assign in_nib   = s_tdata[NIB_W-1:0];
	assign in_bound = s_tdata[NIB_W+WORD_W-1:NIB_W];
	assign in_op    = opcode_t'(s_tuser[0]);

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Wrapping pointer increments
	assign wp_inc = (wp_q == PTR_W'(NCHUNKS - 1)) ? '0 : wp_q + PTR_W'(1);
	assign rp_inc = (rp_q == PTR_W'(NCHUNKS - CHUNKS_PER_WORD)) ? '0
	                : rp_q + PTR_W'(CHUNKS_PER_WORD);
	assign pool_full  = (wp_inc == rp_q);
	assign pool_short = (held_q < PTR_W'(CHUNKS_PER_WORD));

	// RAM read at acceptance, merge write in the following cycle
	assign ram_re    = s_acc;
	assign ram_raddr = (in_op == OP_GET) ? rp_q[PTR_W-1:SEL_W] : wp_q[PTR_W-1:SEL_W];
	assign ram_we    = (state_q == S_MERGE);
	assign nib_shamt = {wsel_q, 2'b00};
	assign ram_wdata = (ram_rdata & ~(WORD_W'(NIB_MASK) << nib_shamt))
	                 | (WORD_W'(nib_q) << nib_shamt);

	nep_ram #(
		.WIDTH (WORD_W),
		.DEPTH (POOL_WORDS)
	) u_pool_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// One restoring remainder step
	assign rem_shift = {rem_q, dvd_q[WORD_W-1]};
	assign rem_sub   = rem_shift - {1'b0, bound_q};
	assign rem_next  = rem_sub[WORD_W] ? rem_shift[WORD_W-1:0] : rem_sub[WORD_W-1:0];

	assign held_ext = {{FILL_W{1'b0}}, held_q};

	// Sequencer and pool pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			held_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						if (in_op == OP_APPEND) begin
							if (pool_full) begin
								state_q <= S_DONE;
							end else begin
								wp_q    <= wp_inc;
								held_q  <= held_q + PTR_W'(1);
								state_q <= S_MERGE;
							end
						end else begin
							if (pool_short) begin
								state_q <= S_DONE;
							end else begin
								rp_q    <= rp_inc;
								held_q  <= held_q - PTR_W'(CHUNKS_PER_WORD);
								state_q <= S_LOAD;
							end
						end
					end
				end
				S_MERGE: state_q <= S_DONE;
				S_LOAD:  state_q <= (bound_q == '0) ? S_DONE : S_DIV;
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output valid: set when a result is loaded, cleared when it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= ((state_q == S_DONE) && out_free) || (out_valid_q && !m_tready);
		end
	end

	// Working payload and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					nib_q       <= in_nib;
					wsel_q      <= wp_q[SEL_W-1:0];
					waddr_q     <= wp_q[PTR_W-1:SEL_W];
					bound_q     <= in_bound;
					res_value_q <= '0;
					if (in_op == OP_APPEND) begin
						res_status_q <= pool_full ? ST_FULL : ST_DONE;
					end else begin
						res_status_q <= pool_short ? ST_EMPTY : ST_DONE;
					end
				end
			end
			S_LOAD: begin
				res_value_q <= ram_rdata;
				dvd_q       <= ram_rdata;
				rem_q       <= '0;
				cnt_q       <= CNT_W'(WORD_W - 1);
			end
			S_DIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					res_value_q <= rem_next;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_value_q  <= res_value_q;
					out_status_q <= res_status_q;
					out_fill_q   <= held_ext[FILL_W-1:0];
					out_en_q     <= (res_status_q != ST_FULL);
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_en_q, out_fill_q, out_value_q};
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire

FILE: test/tb_nibble_entropy_pool.sv
// Testbench for nibble_entropy_pool: streams append and get requests with random stalls on
// both sides and checks every reply against an in-bench model of the ring-buffer pool.
// Depends on nep_pkg and the nibble_entropy_pool RTL.
`timescale 1ns / 1ps

module tb_nibble_entropy_pool;
	import nep_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 36;
	localparam int TAIL_CYCLES = 64;
	localparam logic [FILL_W-1:0] POOL_CAPACITY = FILL_W'(NCHUNKS - 1);

	// One expected reply: word, status, fill level after the request, source enable
	typedef struct packed {
		logic [WORD_W-1:0] value;
		status_t           status;
		logic [FILL_W-1:0] fill;
		logic              enable;
	} pool_reply_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	// Model of the pool contents and pointers
	logic [WORD_W-1:0] pool_mem [POOL_WORDS];
	logic [PTR_W-1:0]  wr_ptr       = '0;
	logic [PTR_W-1:0]  rd_ptr       = '0;
	logic [FILL_W-1:0] held_nibbles = '0;

	pool_reply_t pool_replies[$];
	bit          steady_flow = 1'b0;
	int          error_count = 0;
	int          cycle_count = 0;
	int          n_appends   = 0;
	int          n_dropped   = 0;
	int          n_gets      = 0;
	int          n_refused   = 0;
	int          n_reduced   = 0;

	nibble_entropy_pool dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Advance the pool model by one request and return the reply it should produce
	function automatic pool_reply_t pool_step(opcode_t op, logic [NIB_W-1:0] nib,
			logic [WORD_W-1:0] bound);
		pool_reply_t r;
		r.value  = '0;
		r.status = ST_DONE;
		r.enable = 1'b1;
		if (op == OP_APPEND) begin
			n_appends++;
			if (PTR_W'(wr_ptr + 1'b1) == rd_ptr) begin
				r.status = ST_FULL;
				r.enable = 1'b0;
				n_dropped++;
			end else begin
				pool_mem[wr_ptr[PTR_W-1:SEL_W]][wr_ptr[SEL_W-1:0]*NIB_W +: NIB_W] = nib;
				wr_ptr       = wr_ptr + 1'b1;
				held_nibbles = held_nibbles + 1'b1;
			end
		end else begin
			n_gets++;
			if (held_nibbles < FILL_W'(CHUNKS_PER_WORD)) begin
				r.status = ST_EMPTY;
				n_refused++;
			end else begin
				r.value      = pool_mem[rd_ptr[PTR_W-1:SEL_W]];
				rd_ptr       = rd_ptr + PTR_W'(CHUNKS_PER_WORD);
				held_nibbles = held_nibbles - FILL_W'(CHUNKS_PER_WORD);
				if (bound != '0) begin
					r.value = r.value % bound;
					n_reduced++;
				end
			end
		end
		r.fill = held_nibbles;
		return r;
	endfunction

	// Mix of zero, all-ones, tiny, power-of-two and fully random bounds
	function automatic logic [WORD_W-1:0] pick_bound();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return WORD_W'($urandom_range(1, 16));
			3: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
			default: return $urandom;
		endcase
	endfunction

	// Send one request, with random idle cycles ahead of it, and log its reply
	task automatic send_request(input opcode_t op, input logic [NIB_W-1:0] nib,
			input logic [WORD_W-1:0] bound);
		while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, bound, nib};
		do @(posedge clk); while (!s_tready);
		pool_replies.push_back(pool_step(op, nib, bound));
	endtask

	// Hold off the sender until every outstanding reply has come back
	task automatic wait_all_replies();
		s_tvalid <= 1'b0;
		while (pool_replies.size() != 0) @(posedge clk);
	endtask

	// Empty pool, a word short of a get, nibble extremes, zero and all-ones bounds
	task automatic test_directed();
		logic [NIB_W-1:0] pattern [7];
		pattern = '{4'h0, 4'hF, 4'h1, 4'h2, 4'h4, 4'h8, 4'hA};
		send_request(OP_GET, 4'h0, '0);
		foreach (pattern[i]) send_request(OP_APPEND, pattern[i], '0);
		send_request(OP_GET, 4'h0, '1);
		send_request(OP_APPEND, 4'h5, '1);
		send_request(OP_GET, 4'hF, '0);
		for (int i = 0; i < CHUNKS_PER_WORD; i++) send_request(OP_APPEND, 4'hF, '0);
		send_request(OP_GET, 4'h0, '1);
		send_request(OP_GET, 4'hF, '1);
	endtask

	// Fill to capacity, overflow, free one word, append two nibbles, then drain past empty
	task automatic test_full_pool();
		while (held_nibbles != POOL_CAPACITY)
			send_request(OP_APPEND, NIB_W'($urandom), $urandom);
		repeat (3) send_request(OP_APPEND, NIB_W'($urandom), $urandom);
		send_request(OP_GET, NIB_W'($urandom), WORD_W'(1));
		send_request(OP_APPEND, NIB_W'($urandom), $urandom);
		send_request(OP_APPEND, NIB_W'($urandom), $urandom);
		while (held_nibbles >= FILL_W'(CHUNKS_PER_WORD))
			send_request(OP_GET, NIB_W'($urandom), pick_bound());
		send_request(OP_GET, NIB_W'($urandom), pick_bound());
	endtask

	// Random bursts: runs of appends, runs of gets, and mixed noise
	task automatic test_random();
		int sent;
		int run_len;
		bit paused;
		sent   = 0;
		paused = 1'b0;
		while (sent < 420) begin
			steady_flow = (sent >= 150 && sent < 250);
			if (!paused && sent >= 300) begin
				wait_all_replies();
				paused = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					run_len = $urandom_range(1, 24);
					repeat (run_len) send_request(OP_APPEND, NIB_W'($urandom), $urandom);
				end
				4, 5, 6: begin
					run_len = $urandom_range(1, 4);
					repeat (run_len) send_request(OP_GET, NIB_W'($urandom), pick_bound());
				end
				default: begin
					run_len = $urandom_range(1, 8);
					repeat (run_len)
						send_request(opcode_t'($urandom_range(0, 1)), NIB_W'($urandom),
							pick_bound());
				end
			endcase
			sent += run_len;
		end
		steady_flow = 1'b0;
	endtask

	// Receiver: random back-pressure, compare each reply with the oldest expectation
	always @(posedge clk) begin
		pool_reply_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pool_replies.size() == 0) begin
				$error("unexpected reply: tdata %h tuser %0d", m_tdata, m_tuser);
				error_count++;
			end else begin
				exp_r = pool_replies.pop_front();
				if (m_tdata[31:0] !== exp_r.value) begin
					$error("random_value: expected %h, got %h", exp_r.value, m_tdata[31:0]);
					error_count++;
				end
				if (m_tuser !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, m_tuser);
					error_count++;
				end
				if (m_tdata[38:32] !== exp_r.fill) begin
					$error("fill_level: expected %0d, got %0d", exp_r.fill, m_tdata[38:32]);
					error_count++;
				end
				if (m_tdata[39] !== exp_r.enable) begin
					$error("source_enable: expected %0d, got %0d", exp_r.enable, m_tdata[39]);
					error_count++;
				end
			end
		end
		m_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		foreach (pool_mem[i]) pool_mem[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_pool();
		test_random();
		wait_all_replies();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d appends (%0d dropped on a full pool) and %0d gets", n_appends,
			n_dropped, n_gets);
		$display("Gets: %0d refused as empty, %0d reduced by a nonzero bound", n_refused,
			n_reduced);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/nep_pkg.sv
rtl/core/nep_ram.sv
rtl/core/nibble_entropy_pool.sv
test/tb_nibble_entropy_pool.sv
